### rtl/core/ctc_pkg.sv
package ctc_pkg;

   localparam int MAX_ROWS    = 1024;
   localparam int MAX_ENTRIES = 4096;
   localparam int VALUE_WIDTH = 32;

   localparam int ROW_W  = 10;
   localparam int NROW_W = $clog2(MAX_ROWS + 1);
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int RP_AW  = $clog2(MAX_ROWS);
   localparam int ENT_AW = $clog2(MAX_ENTRIES);
   localparam int OP_W   = 3;
   localparam int STAT_W = 2;
   localparam int ELEM_W = 32;

   localparam logic [OP_W-1:0] OP_LOAD   = 3'd0;
   localparam logic [OP_W-1:0] OP_BUILD  = 3'd1;
   localparam logic [OP_W-1:0] OP_RD_PTR = 3'd2;
   localparam logic [OP_W-1:0] OP_RD_ENT = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE     = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOT_BUILT = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_RDWAIT, S_CLR, S_CNT_A, S_CNT_B, S_CNT_C,
      S_PFX_A, S_PFX_B, S_SCT_A, S_SCT_B, S_SCT_C, S_FIN, S_RESP
   } state_type;

   typedef enum logic [3:0] {
      DP_NONE, DP_TAKE, DP_EXEC, DP_RDOUT, DP_CLR, DP_CNT_A, DP_CNT_B, DP_CNT_C,
      DP_PFX_A, DP_PFX_B, DP_SCT_A, DP_SCT_B, DP_SCT_C, DP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      cfg_we;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            rd_go;
      logic            last_row;
      logic            last_entry;
      logic            no_entries;
   } stat_type;

   typedef struct packed {
      logic [ROW_W-1:0]       row;
      logic [ROW_W-1:0]       col;
      logic [VALUE_WIDTH-1:0] value;
   } coord_type;

   typedef struct packed {
      logic [ROW_W-1:0]       col;
      logic [VALUE_WIDTH-1:0] value;
   } csr_ent_type;

endpackage

### rtl/core/coo_to_csr_converter.sv
// Coordinate to compressed-row converter for a square sparse matrix.
// Request beats carry an opcode (load entry, build, read row pointer,
// read entry, clear) with row, col, value and index fields; every request
// produces exactly one response beat with status, row pointer, column and
// element. The csr channel writes the row count, and is taken only while
// no request is in flight; a write discards all loaded entries.
// One request is handled at a time. A load, clear or rejected request
// goes from the execute state to the response; a read first passes a wait
// state, as the stores have registered read data. A build runs a clear
// pass over the rows, then, if entries are loaded, a count pass over the
// entries (CNT_A, CNT_B, CNT_C), a prefix pass over the rows (PFX_A,
// PFX_B) and a scatter pass over the entries (SCT_A, SCT_B, SCT_C). The
// next request is accepted the cycle after the response beat is taken.
// Reset empties the entry store, clears the built flag and sets the row
// count to 1024; no memory clearing is needed. While rsp_stall is high the
// response beat holds and req_stall stays high.
module coo_to_csr_converter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [ctc_pkg::OP_W-1:0]   req_opcode,
   input  logic [ctc_pkg::ROW_W-1:0]  req_row,
   input  logic [ctc_pkg::ROW_W-1:0]  req_col,
   input  logic [ctc_pkg::ELEM_W-1:0] req_value,
   input  logic [ctc_pkg::CNT_W-1:0]  req_index,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [ctc_pkg::STAT_W-1:0] rsp_status,
   output logic [ctc_pkg::CNT_W-1:0]  rsp_row_pointer,
   output logic [ctc_pkg::ROW_W-1:0]  rsp_column,
   output logic [ctc_pkg::ELEM_W-1:0] rsp_element,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [ctc_pkg::NROW_W-1:0] csr_num_rows
);
   import ctc_pkg::*;

   cmd_type  cmd;
   stat_type st;

   ctc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .st        (st),
      .cmd       (cmd)
   );

   ctc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .csr_num_rows    (csr_num_rows),
      .req_opcode      (req_opcode),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_value       (req_value),
      .req_index       (req_index),
      .rsp_status      (rsp_status),
      .rsp_row_pointer (rsp_row_pointer),
      .rsp_column      (rsp_column),
      .rsp_element     (rsp_element)
   );

endmodule

### rtl/core/ctc_ctrl.sv
module ctc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  ctc_pkg::stat_type st,
   output ctc_pkg::cmd_type  cmd
);
   import ctc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (st.op == OP_BUILD) state_in = S_CLR;
            else if (st.rd_go) state_in = S_RDWAIT;
            else state_in = S_RESP;
         end
         S_RDWAIT: state_in = S_RESP;
         S_CLR: begin
            if (st.last_row) state_in = st.no_entries ? S_FIN : S_CNT_A;
         end
         S_CNT_A: state_in = S_CNT_B;
         S_CNT_B: state_in = S_CNT_C;
         S_CNT_C: state_in = st.last_entry ? S_PFX_A : S_CNT_A;
         S_PFX_A: state_in = S_PFX_B;
         S_PFX_B: state_in = st.last_row ? S_SCT_A : S_PFX_A;
         S_SCT_A: state_in = S_SCT_B;
         S_SCT_B: state_in = S_SCT_C;
         S_SCT_C: state_in = st.last_entry ? S_FIN : S_SCT_A;
         S_FIN:   state_in = S_RESP;
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op     = DP_NONE;
      cmd.cfg_we = 1'b0;
      req_stall  = (state_ff != S_IDLE);
      rsp_valid  = (state_ff == S_RESP);
      csr_ready  = (state_ff == S_IDLE) && !req_valid;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) cmd.op = DP_TAKE;
            cmd.cfg_we = csr_valid && !req_valid;
         end
         S_EXEC:   cmd.op = DP_EXEC;
         S_RDWAIT: cmd.op = DP_RDOUT;
         S_CLR:    cmd.op = DP_CLR;
         S_CNT_A:  cmd.op = DP_CNT_A;
         S_CNT_B:  cmd.op = DP_CNT_B;
         S_CNT_C:  cmd.op = DP_CNT_C;
         S_PFX_A:  cmd.op = DP_PFX_A;
         S_PFX_B:  cmd.op = DP_PFX_B;
         S_SCT_A:  cmd.op = DP_SCT_A;
         S_SCT_B:  cmd.op = DP_SCT_B;
         S_SCT_C:  cmd.op = DP_SCT_C;
         S_FIN:    cmd.op = DP_FINISH;
         default:  cmd.op = DP_NONE;
      endcase
   end

endmodule

### rtl/core/ctc_datapath.sv
module ctc_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  ctc_pkg::cmd_type                   cmd,
   output ctc_pkg::stat_type                  st,
   input  logic [ctc_pkg::NROW_W-1:0]         csr_num_rows,
   input  logic [ctc_pkg::OP_W-1:0]           req_opcode,
   input  logic [ctc_pkg::ROW_W-1:0]          req_row,
   input  logic [ctc_pkg::ROW_W-1:0]          req_col,
   input  logic [ctc_pkg::ELEM_W-1:0]         req_value,
   input  logic [ctc_pkg::CNT_W-1:0]          req_index,
   output logic [ctc_pkg::STAT_W-1:0]         rsp_status,
   output logic [ctc_pkg::CNT_W-1:0]          rsp_row_pointer,
   output logic [ctc_pkg::ROW_W-1:0]          rsp_column,
   output logic [ctc_pkg::ELEM_W-1:0]         rsp_element
);
   import ctc_pkg::*;

   coord_type   coord_mem [MAX_ENTRIES];
   logic [CNT_W-1:0] rp_mem [MAX_ROWS];
   csr_ent_type csr_mem [MAX_ENTRIES];

   coord_type        coord_q;
   logic [CNT_W-1:0] rp_q;
   csr_ent_type      csr_q;

   logic [NROW_W-1:0] num_rows_ff, num_rows_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              built_ff, built_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  run_ff, run_in;

   logic [OP_W-1:0]   op_ff, op_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ROW_W-1:0]  col_ff, col_in;
   logic [ELEM_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;

   logic [STAT_W-1:0] status_ff, status_in;
   logic [CNT_W-1:0]  rp_res_ff, rp_res_in;
   logic [ROW_W-1:0]  col_res_ff, col_res_in;
   logic [ELEM_W-1:0] elem_res_ff, elem_res_in;

   logic [NROW_W-1:0] n_use;
   logic [CNT_W-1:0]  n_ext;

   logic              coord_we, coord_re, rp_we, rp_re, csr_we, csr_re;
   logic [ENT_AW-1:0] coord_waddr, coord_raddr, csr_waddr, csr_raddr;
   logic [RP_AW-1:0]  rp_waddr, rp_raddr;
   logic [CNT_W-1:0]  rp_wdata;
   coord_type         coord_wdata;

   always_comb begin
      if (num_rows_ff == '0) n_use = NROW_W'(1);
      else if (num_rows_ff > NROW_W'(MAX_ROWS)) n_use = NROW_W'(MAX_ROWS);
      else n_use = num_rows_ff;
   end
   assign n_ext = CNT_W'(n_use);

   assign st.op         = op_ff;
   assign st.last_row   = (i_ff == n_ext - CNT_W'(1));
   assign st.last_entry = (i_ff == count_ff - CNT_W'(1));
   assign st.no_entries = (count_ff == '0);
   assign st.rd_go      = built_ff &&
                          (((op_ff == OP_RD_PTR) && (idx_ff <= n_ext)) ||
                           ((op_ff == OP_RD_ENT) && (idx_ff < count_ff)));

   always_comb begin
      num_rows_in = num_rows_ff;
      count_in    = count_ff;
      built_in    = built_ff;
      i_in        = i_ff;
      run_in      = run_ff;
      op_in       = op_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      val_in      = val_ff;
      idx_in      = idx_ff;
      status_in   = status_ff;
      rp_res_in   = rp_res_ff;
      col_res_in  = col_res_ff;
      elem_res_in = elem_res_ff;
      coord_we    = 1'b0;
      coord_re    = 1'b0;
      rp_we       = 1'b0;
      rp_re       = 1'b0;
      csr_we      = 1'b0;
      csr_re      = 1'b0;
      coord_waddr = count_ff[ENT_AW-1:0];
      coord_raddr = i_ff[ENT_AW-1:0];
      coord_wdata = '{row: row_ff, col: col_ff, value: val_ff};
      rp_waddr    = i_ff[RP_AW-1:0];
      rp_raddr    = i_ff[RP_AW-1:0];
      rp_wdata    = '0;
      csr_waddr   = rp_q[ENT_AW-1:0];
      csr_raddr   = idx_ff[ENT_AW-1:0];

      if (cmd.cfg_we) begin
         num_rows_in = csr_num_rows;
         count_in    = '0;
         built_in    = 1'b0;
      end

      case (cmd.op)
         DP_TAKE: begin
            op_in  = req_opcode;
            row_in = req_row;
            col_in = req_col;
            val_in = req_value;
            idx_in = req_index;
         end
         DP_EXEC: begin
            status_in   = ST_OK;
            rp_res_in   = '0;
            col_res_in  = '0;
            elem_res_in = '0;
            i_in        = '0;
            run_in      = '0;
            case (op_ff)
               OP_LOAD: begin
                  if (({1'b0, row_ff} >= n_use) || ({1'b0, col_ff} >= n_use)) begin
                     status_in = ST_RANGE;
                  end else if (count_ff == CNT_W'(MAX_ENTRIES)) begin
                     status_in = ST_FULL;
                  end else begin
                     coord_we = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                     built_in = 1'b0;
                  end
               end
               OP_BUILD: status_in = ST_OK;
               OP_RD_PTR, OP_RD_ENT: begin
                  if (!built_ff) status_in = ST_NOT_BUILT;
                  else if (!st.rd_go) status_in = ST_RANGE;
               end
               OP_CLEAR: begin
                  count_in = '0;
                  built_in = 1'b0;
               end
               default: status_in = ST_RANGE;
            endcase
            // Pointer k of the finished table sits in word k-1 after the scatter.
            rp_re    = st.rd_go && (op_ff == OP_RD_PTR);
            rp_raddr = RP_AW'(idx_ff - CNT_W'(1));
            csr_re   = st.rd_go && (op_ff == OP_RD_ENT);
         end
         DP_RDOUT: begin
            if (op_ff == OP_RD_PTR) begin
               rp_res_in = (idx_ff == '0) ? '0 : rp_q;
            end else begin
               col_res_in  = csr_q.col;
               elem_res_in = ELEM_W'(csr_q.value);
            end
         end
         DP_CLR: begin
            rp_we = 1'b1;
            i_in  = st.last_row ? '0 : i_ff + CNT_W'(1);
         end
         DP_CNT_A, DP_SCT_A: coord_re = 1'b1;
         DP_CNT_B, DP_SCT_B: begin
            rp_re    = 1'b1;
            rp_raddr = RP_AW'(coord_q.row);
         end
         DP_CNT_C: begin
            rp_we    = 1'b1;
            rp_waddr = RP_AW'(coord_q.row);
            rp_wdata = rp_q + CNT_W'(1);
            i_in     = st.last_entry ? '0 : i_ff + CNT_W'(1);
         end
         DP_PFX_A: rp_re = 1'b1;
         DP_PFX_B: begin
            rp_we    = 1'b1;
            rp_wdata = run_ff;
            run_in   = run_ff + rp_q;
            i_in     = st.last_row ? '0 : i_ff + CNT_W'(1);
         end
         DP_SCT_C: begin
            csr_we   = 1'b1;
            rp_we    = 1'b1;
            rp_waddr = RP_AW'(coord_q.row);
            rp_wdata = rp_q + CNT_W'(1);
            i_in     = i_ff + CNT_W'(1);
         end
         DP_FINISH: built_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= NROW_W'(MAX_ROWS);
         count_ff    <= '0;
         built_ff    <= 1'b0;
      end else begin
         num_rows_ff <= num_rows_in;
         count_ff    <= count_in;
         built_ff    <= built_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      run_ff      <= run_in;
      op_ff       <= op_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      val_ff      <= val_in;
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      rp_res_ff   <= rp_res_in;
      col_res_ff  <= col_res_in;
      elem_res_ff <= elem_res_in;
   end

   always_ff @(posedge clock) begin
      if (coord_we) coord_mem[coord_waddr] <= coord_wdata;
      if (coord_re) coord_q <= coord_mem[coord_raddr];
   end

   always_ff @(posedge clock) begin
      if (rp_we) rp_mem[rp_waddr] <= rp_wdata;
      if (rp_re) rp_q <= rp_mem[rp_raddr];
   end

   always_ff @(posedge clock) begin
      if (csr_we) csr_mem[csr_waddr] <= '{col: coord_q.col, value: coord_q.value};
      if (csr_re) csr_q <= csr_mem[csr_raddr];
   end

   assign rsp_status      = status_ff;
   assign rsp_row_pointer = rp_res_ff;
   assign rsp_column      = col_res_ff;
   assign rsp_element     = elem_res_ff;

   a_finish_builds: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_FINISH) |=> built_ff)
      else $error("build finished without marking the table built");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count beyond store size");

   a_cfg_discards: assert property (@(posedge clock) disable iff (reset)
      cmd.cfg_we |=> (count_ff == '0) && !built_ff)
      else $error("row count write did not discard entries");

endmodule

### test/tb_coo_to_csr_converter.sv
`timescale 1ns / 100ps

module tb_coo_to_csr_converter;
   import ctc_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED_MAX = 3'd7;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [ROW_W-1:0]  row;
      logic [ROW_W-1:0]  col;
      logic [ELEM_W-1:0] value;
      logic [CNT_W-1:0]  index;
   } req_type;

   typedef struct {
      logic [STAT_W-1:0] status;
      logic [CNT_W-1:0]  row_pointer;
      logic [ROW_W-1:0]  column;
      logic [ELEM_W-1:0] element;
   } rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [OP_W-1:0]   req_opcode = '0;
   logic [ROW_W-1:0]  req_row = '0;
   logic [ROW_W-1:0]  req_col = '0;
   logic [ELEM_W-1:0] req_value = '0;
   logic [CNT_W-1:0]  req_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [CNT_W-1:0]  rsp_row_pointer;
   logic [ROW_W-1:0]  rsp_column;
   logic [ELEM_W-1:0] rsp_element;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [NROW_W-1:0] csr_num_rows = '0;

   coo_to_csr_converter u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_row(req_row), .req_col(req_col), .req_value(req_value),
      .req_index(req_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_row_pointer(rsp_row_pointer), .rsp_column(rsp_column),
      .rsp_element(rsp_element),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_num_rows(csr_num_rows)
   );

   // Shadow copy of the converter state.
   logic [ROW_W-1:0]  coo_row [MAX_ENTRIES];
   logic [ROW_W-1:0]  coo_col [MAX_ENTRIES];
   logic [ELEM_W-1:0] coo_val [MAX_ENTRIES];
   logic [ROW_W-1:0]  csr_col [MAX_ENTRIES];
   logic [ELEM_W-1:0] csr_val [MAX_ENTRIES];
   logic [CNT_W-1:0]  row_ptr [MAX_ROWS+1];
   int                loaded = 0;
   bit                is_built = 0;
   logic [NROW_W-1:0] row_setting = NROW_W'(MAX_ROWS);

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   bit   failed = 0;
   bit   quiet = 0;
   bit   req_taken = 0;
   int   send_gap = 0;
   int   stall_left = 0;
   int   gen_count;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int active_rows();
      if (row_setting == 0) return 1;
      if (row_setting > MAX_ROWS) return MAX_ROWS;
      return int'(row_setting);
   endfunction

   function automatic void build_csr_shadow();
      int n;
      int fill [MAX_ROWS];
      int run;
      int slot;
      n = active_rows();
      for (int r = 0; r < n; r++) fill[r] = 0;
      for (int i = 0; i < loaded; i++) fill[coo_row[i]]++;
      run = 0;
      for (int r = 0; r < n; r++) begin
         row_ptr[r] = CNT_W'(run);
         run += fill[r];
         fill[r] = int'(row_ptr[r]);
      end
      row_ptr[n] = CNT_W'(loaded);
      // Walking entries in load order keeps each row stable.
      for (int i = 0; i < loaded; i++) begin
         slot = fill[coo_row[i]];
         csr_col[slot] = coo_col[i];
         csr_val[slot] = coo_val[i];
         fill[coo_row[i]]++;
      end
      is_built = 1;
   endfunction

   function automatic rsp_type predict_response(req_type q);
      rsp_type e;
      int n;
      n = active_rows();
      e = '{ST_OK, '0, '0, '0};
      case (q.op)
         OP_LOAD: begin
            if (q.row >= n || q.col >= n) e.status = ST_RANGE;
            else if (loaded >= MAX_ENTRIES) e.status = ST_FULL;
            else begin
               coo_row[loaded] = q.row;
               coo_col[loaded] = q.col;
               coo_val[loaded] = q.value;
               loaded++;
               is_built = 0;
            end
         end
         OP_BUILD: build_csr_shadow();
         OP_RD_PTR: begin
            if (!is_built) e.status = ST_NOT_BUILT;
            else if (q.index > n) e.status = ST_RANGE;
            else e.row_pointer = row_ptr[q.index];
         end
         OP_RD_ENT: begin
            if (!is_built) e.status = ST_NOT_BUILT;
            else if (q.index >= loaded) e.status = ST_RANGE;
            else begin
               e.column  = csr_col[q.index];
               e.element = csr_val[q.index];
            end
         end
         OP_CLEAR: begin
            loaded = 0;
            is_built = 0;
         end
         default: e.status = ST_RANGE;
      endcase
      return e;
   endfunction

   // Request driver.
   always @(negedge clock) begin
      req_type q;
      if (!reset && (!req_valid || req_taken)) begin
         req_taken = 0;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            if (!quiet && $urandom_range(0, 11) == 0) begin
               send_gap = $urandom_range(1, 19) - 1;
               req_valid <= 1'b0;
            end else begin
               q = pending_reqs.pop_front();
               req_opcode <= q.op;
               req_row    <= q.row;
               req_col    <= q.col;
               req_value  <= q.value;
               req_index  <= q.index;
               req_valid  <= 1'b1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall bursts.
   always @(negedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Accept tracking and response checking.
   always @(posedge clock) begin
      req_type q;
      rsp_type e;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            q = '{req_opcode, req_row, req_col, req_value, req_index};
            expected_rsps.push_back(predict_response(q));
            req_taken = 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response beat, status %0d", $realtime, rsp_status);
               failed = 1;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_status !== e.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $realtime, e.status, rsp_status);
                  failed = 1;
               end
               if (rsp_row_pointer !== e.row_pointer) begin
                  $display("%0t: row_pointer expected %0d actual %0d",
                           $realtime, e.row_pointer, rsp_row_pointer);
                  failed = 1;
               end
               if (rsp_column !== e.column) begin
                  $display("%0t: column expected %0d actual %0d",
                           $realtime, e.column, rsp_column);
                  failed = 1;
               end
               if (rsp_element !== e.element) begin
                  $display("%0t: element expected %h actual %h",
                           $realtime, e.element, rsp_element);
                  failed = 1;
               end
            end
         end
      end
   end

   task automatic add_req(logic [OP_W-1:0] op, int row, int col,
                          logic [ELEM_W-1:0] value, int index);
      pending_reqs.push_back('{op, ROW_W'(row), ROW_W'(col), value, CNT_W'(index)});
      gen_count++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_rows(int rows);
      wait_idle();
      csr_num_rows <= NROW_W'(rows);
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      row_setting = NROW_W'(rows);
      loaded = 0;
      is_built = 0;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [ELEM_W-1:0] rand_value();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   // One load/build/readback sequence with random content and some noise.
   task automatic matrix_sequence(int n);
      int k;
      int rr;
      int cc;
      k = $urandom_range(0, 14);
      for (int i = 0; i < k; i++) begin
         rr = $urandom_range(0, n - 1);
         cc = $urandom_range(0, n - 1);
         if ($urandom_range(0, 9) == 0) rr = $urandom_range(0, 1023);
         if ($urandom_range(0, 9) == 0) cc = $urandom_range(0, 1023);
         add_req(OP_LOAD, rr, cc, rand_value(), $urandom_range(0, 8191));
      end
      if ($urandom_range(0, 7) == 0) add_req(OP_RD_ENT, 0, 0, 0, 0);
      add_req(OP_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom(), $urandom_range(0, 8191));
      k = $urandom_range(2, 16);
      for (int i = 0; i < k; i++) begin
         case ($urandom_range(0, 9))
            0: add_req(OP_RD_PTR, 0, 0, 0, $urandom_range(0, 8191));
            1: add_req(OP_RD_ENT, 0, 0, 0, $urandom_range(0, 8191));
            2: add_req(OP_W'($urandom_range(OP_CLEAR + 1, OP_UNUSED_MAX)),
                       $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom(),
                       $urandom_range(0, 8191));
            3, 4, 5: add_req(OP_RD_PTR, 0, 0, 0, $urandom_range(0, n + 1));
            default: add_req(OP_RD_ENT, $urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom(), $urandom_range(0, 16));
         endcase
      end
      case ($urandom_range(0, 5))
         0: add_req(OP_CLEAR, 0, 0, 0, 0);
         1: begin
            add_req(OP_LOAD, $urandom_range(0, n - 1), $urandom_range(0, n - 1), $urandom(), 0);
            add_req(OP_RD_PTR, 0, 0, 0, 0);
         end
         default: ;
      endcase
   endtask

   initial begin
      int settings [7];
      settings = '{1024, 1, 0, 4, 2047, 37, 16};
      gen_count = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reads before build, unknown ops, empty build, field extremes.
      add_req(OP_RD_PTR, 0, 0, 0, 0);
      add_req(OP_RD_ENT, 0, 0, 0, 0);
      add_req(OP_UNUSED_MAX, 1023, 1023, '1, 8191);
      add_req(OP_W'(OP_CLEAR + 1), 0, 0, 0, 0);
      add_req(OP_BUILD, 0, 0, 0, 0);
      add_req(OP_RD_PTR, 0, 0, 0, 0);
      add_req(OP_RD_PTR, 0, 0, 0, 1024);
      add_req(OP_RD_PTR, 0, 0, 0, 1025);
      add_req(OP_RD_ENT, 0, 0, 0, 0);
      add_req(OP_LOAD, 1023, 1023, '1, 8191);
      add_req(OP_LOAD, 0, 0, '0, 0);
      add_req(OP_LOAD, 1023, 0, 32'h5555_aaaa, 0);
      add_req(OP_LOAD, 0, 5, 32'haaaa_5555, 0);
      add_req(OP_RD_PTR, 0, 0, 0, 0);
      add_req(OP_BUILD, 0, 0, 0, 0);
      add_req(OP_RD_PTR, 0, 0, 0, 1);
      add_req(OP_RD_PTR, 0, 0, 0, 1024);
      add_req(OP_RD_ENT, 0, 0, 0, 0);
      add_req(OP_RD_ENT, 0, 0, 0, 1);
      add_req(OP_RD_ENT, 0, 0, 0, 3);
      add_req(OP_RD_ENT, 0, 0, 0, 4);
      add_req(OP_CLEAR, 0, 0, 0, 0);
      add_req(OP_RD_ENT, 0, 0, 0, 0);

      foreach (settings[s]) begin
         write_rows(settings[s]);
         add_req(OP_LOAD, 1, 0, 0, 0);
         add_req(OP_LOAD, 0, 1, 0, 0);
         gen_count = 0;
         while (gen_count < 220) begin
            matrix_sequence(active_rows());
         end
      end

      // Full entry store, with no idling on either side.
      write_rows(2047);
      wait_idle();
      quiet = 1;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         add_req(OP_LOAD, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom(), 0);
      end
      add_req(OP_LOAD, 3, 3, '1, 0);
      add_req(OP_LOAD, 1023, 1023, 0, 0);
      add_req(OP_BUILD, 0, 0, 0, 0);
      add_req(OP_RD_PTR, 0, 0, 0, 1024);
      add_req(OP_RD_PTR, 0, 0, 0, 512);
      add_req(OP_RD_ENT, 0, 0, 0, MAX_ENTRIES - 1);
      add_req(OP_RD_ENT, 0, 0, 0, MAX_ENTRIES);
      add_req(OP_RD_ENT, 0, 0, 0, 8191);
      for (int i = 0; i < 40; i++) add_req(OP_RD_ENT, 0, 0, 0, $urandom_range(0, 4095));
      wait_idle();
      repeat (20) @(negedge clock);

      if (!failed) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
